/* rtl/core/dfsp_pkg.sv */
// Shared types and character constants for the drive filename syntax parser.
package dfsp_pkg;

  localparam int CH_W   = 8;
  localparam int POS_W  = 8;
  localparam int RES_W  = 40;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_AT    = 8'h40;
  localparam logic [CH_W-1:0] CH_COLON = 8'h3A;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CH_W-1:0] CH_QUEST = 8'h3F;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CH_W-1:0] CH_QUOTE = 8'h22;
  localparam logic [CH_W-1:0] CH_PIPE  = 8'h7C;
  localparam logic [CH_W-1:0] CH_LT    = 8'h3C;
  localparam logic [CH_W-1:0] CH_GT    = 8'h3E;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_THREE = 8'h33;

  localparam logic [POS_W-1:0] MAX_LENGTH_RESET = 8'd255;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_NUL,
    CLS_AT,
    CLS_COLON,
    CLS_COMMA,
    CLS_QUEST,
    CLS_STAR,
    CLS_FORBID
  } ch_class_t;

  // One classified item as it sits in the queue.
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    ch_class_t       cls;
  } item_t;

  // Result layout: first member is the top bits, replace lands in bit 0.
  typedef struct packed {
    logic [POS_W-1:0] param_start;
    logic             has_param;
    logic [POS_W-1:0] name_len;
    logic [POS_W-1:0] name_start;
    logic [1:0]       unit;
    logic [POS_W-1:0] cmd_len;
    logic             has_command;
    logic             illegal;
    logic             wildcard_res;
    logic             pattern;
    logic             replace;
  } result_t;

endpackage

/* rtl/core/dfsp_front.sv */
// Front end: accepts input bytes and tags each with its syntax class.
module dfsp_front import dfsp_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [CH_W-1:0] s_tdata,   // [7:0] ch
  input  logic            s_tlast,   // last
  input  logic            q_full,
  output logic            q_push,
  output item_t           q_item
);

  ch_class_t cls;

  always_comb begin
    case (s_tdata)
      CH_NUL:   cls = CLS_NUL;
      CH_AT:    cls = CLS_AT;
      CH_COLON: cls = CLS_COLON;
      CH_COMMA: cls = CLS_COMMA;
      CH_QUEST: cls = CLS_QUEST;
      CH_STAR:  cls = CLS_STAR;
      CH_SLASH, CH_BSLASH, CH_QUOTE, CH_PIPE, CH_LT, CH_GT: cls = CLS_FORBID;
      default:  cls = CLS_OTHER;
    endcase
  end

  // Registered ready: take an item whenever the queue has room.
  logic ready_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      ready_q <= 1'b0;
    end else begin
      ready_q <= 1'b1;
    end
  end

  assign s_tready   = ready_q & ~q_full;
  assign q_push     = s_tvalid & s_tready;
  assign q_item.ch  = s_tdata;
  assign q_item.last = s_tlast;
  assign q_item.cls = cls;

endmodule

/* rtl/core/dfsp_queue.sv */
// Short queue of classified items between the front and back ends.
module dfsp_queue import dfsp_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign pop_item  = mem[rd_ptr];

endmodule

/* rtl/core/dfsp_back.sv */
// Back end: applies each item to the name state and registers the result.
module dfsp_back import dfsp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_data,
  input  logic             q_not_empty,
  input  item_t            q_item,
  output logic             q_pop,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [RES_W-1:0] m_tdata
);

  logic [POS_W-1:0] max_length;

  logic [POS_W-1:0] position, position_next;
  logic             scan_done, scan_done_next;
  logic             halted, halted_next;
  logic [POS_W-1:0] start_pos, start_pos_next;
  logic [POS_W-1:0] end_pos, end_pos_next;
  logic             end_from_mark, end_from_mark_next;
  logic             colon_seen, colon_seen_next;
  logic [POS_W-1:0] cmd_length, cmd_length_next;
  logic [CH_W-1:0]  prev_char, prev_char_next;
  logic [CH_W-1:0]  cmd_last_char, cmd_last_char_next;
  logic             f_replace, f_replace_next;
  logic             f_pattern, f_pattern_next;
  logic             f_wildcard, f_wildcard_next;
  logic             f_illegal, f_illegal_next;
  logic             f_param, f_param_next;
  logic [POS_W-1:0] param_pos, param_pos_next;

  result_t          res, res_next;
  logic             first_at;
  logic [POS_W-1:0] clen;
  logic [POS_W-1:0] name_end;
  logic [CH_W-1:0]  unit_diff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_data;
    end
  end

  // Hold a last item until the output register is free.
  assign q_pop = q_not_empty & (~q_item.last | ~m_tvalid | m_tready);

  always_comb begin
    position_next      = position;
    scan_done_next     = scan_done;
    halted_next        = halted;
    start_pos_next     = start_pos;
    end_pos_next       = end_pos;
    end_from_mark_next = end_from_mark;
    colon_seen_next    = colon_seen;
    cmd_length_next    = cmd_length;
    prev_char_next     = prev_char;
    cmd_last_char_next = cmd_last_char;
    f_replace_next     = f_replace;
    f_pattern_next     = f_pattern;
    f_wildcard_next    = f_wildcard;
    f_illegal_next     = f_illegal;
    f_param_next       = f_param;
    param_pos_next     = param_pos;
    first_at = (position == '0) && (q_item.cls == CLS_AT);

    if (!scan_done) begin
      if (first_at) begin
        f_replace_next = 1'b1;
        start_pos_next = POS_W'(1);
      end
      if (q_item.cls == CLS_NUL || position >= max_length) begin
        scan_done_next = 1'b1;
      end else begin
        if (!first_at && !halted) begin
          case (q_item.cls)
            CLS_COLON: begin
              f_pattern_next  = 1'b0;
              f_wildcard_next = 1'b0;
              if (!colon_seen) begin
                colon_seen_next    = 1'b1;
                cmd_length_next    = position - start_pos;
                cmd_last_char_next = prev_char;
                start_pos_next     = position + POS_W'(1);
              end else begin
                f_illegal_next = 1'b1;
              end
            end
            CLS_COMMA: begin
              f_param_next       = 1'b1;
              param_pos_next     = position + POS_W'(1);
              end_pos_next       = position;
              end_from_mark_next = 1'b1;
              halted_next        = 1'b1;
            end
            CLS_QUEST: begin
              f_pattern_next = 1'b1;
            end
            CLS_STAR: begin
              f_wildcard_next    = 1'b1;
              end_pos_next       = position;
              end_from_mark_next = 1'b1;
            end
            CLS_FORBID: begin
              f_illegal_next     = 1'b1;
              end_from_mark_next = 1'b0;
              halted_next        = 1'b1;
            end
            default: begin
            end
          endcase
        end
        prev_char_next = q_item.ch;
        position_next  = position + POS_W'(1);
      end
    end
  end

  // Result from the state as it stands after this item.
  always_comb begin
    clen      = colon_seen_next ? cmd_length_next : '0;
    name_end  = end_from_mark_next ? end_pos_next : position_next;
    unit_diff = cmd_last_char_next - CH_ZERO;
    res_next  = '0;
    if (clen != '0 && (cmd_last_char_next inside {[CH_ZERO:CH_THREE]})) begin
      res_next.unit = unit_diff[1:0];
      clen          = clen - POS_W'(1);
    end
    res_next.replace      = f_replace_next;
    res_next.pattern      = f_pattern_next;
    res_next.wildcard_res = f_wildcard_next;
    res_next.illegal      = f_illegal_next;
    res_next.has_command  = (clen != '0);
    res_next.cmd_len      = clen;
    res_next.name_start   = start_pos_next;
    res_next.name_len     = name_end - start_pos_next;
    res_next.has_param    = f_param_next;
    res_next.param_start  = f_param_next ? param_pos_next : '0;
  end

  always_ff @(posedge clk) begin
    if (rst || (q_pop && q_item.last)) begin
      position      <= '0;
      scan_done     <= 1'b0;
      halted        <= 1'b0;
      start_pos     <= '0;
      end_pos       <= '0;
      end_from_mark <= 1'b0;
      colon_seen    <= 1'b0;
      cmd_length    <= '0;
      prev_char     <= '0;
      cmd_last_char <= '0;
      f_replace     <= 1'b0;
      f_pattern     <= 1'b0;
      f_wildcard    <= 1'b0;
      f_illegal     <= 1'b0;
      f_param       <= 1'b0;
      param_pos     <= '0;
    end else if (q_pop) begin
      position      <= position_next;
      scan_done     <= scan_done_next;
      halted        <= halted_next;
      start_pos     <= start_pos_next;
      end_pos       <= end_pos_next;
      end_from_mark <= end_from_mark_next;
      colon_seen    <= colon_seen_next;
      cmd_length    <= cmd_length_next;
      prev_char     <= prev_char_next;
      cmd_last_char <= cmd_last_char_next;
      f_replace     <= f_replace_next;
      f_pattern     <= f_pattern_next;
      f_wildcard    <= f_wildcard_next;
      f_illegal     <= f_illegal_next;
      f_param       <= f_param_next;
      param_pos     <= param_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop && q_item.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      res <= res_next;
    end
  end

  assign m_tdata = res;

endmodule

/* rtl/core/drive_filename_syntax_parser.sv */
// Top level of the drive filename syntax parser.
// Takes one filename byte per cycle on the s_ side while the queue has room
// and gives one 40-bit structure report on the m_ side for each byte marked
// tlast. Bytes are classified on entry and pass through a QUEUE_DEPTH-entry
// queue to the state-update stage, which retires one byte per cycle unless a
// last byte waits for the output register; the report is registered there.
// The input keeps running at one byte per cycle while a report waits; only
// a further last byte waits for that register to drain, and the queue then
// fills behind it. The user must write max_length through cfg_ only while
// the block is idle, which it does not enforce; writes act on the next byte.
module drive_filename_syntax_parser import dfsp_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] ch
  input  logic             s_tlast,   // last
  output logic             m_tvalid,
  input  logic             m_tready,
  // [0] replace, [1] pattern, [2] wildcard_res, [3] illegal, [4] has_command,
  // [12:5] cmd_len, [14:13] unit, [22:15] name_start, [30:23] name_len,
  // [31] has_param, [39:32] param_start
  output logic [39:0]      m_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [7:0]       cfg_data   // max_length
);

  item_t push_item;
  item_t pop_item;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_not_empty;

  dfsp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  dfsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  dfsp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

/* rtl/core/dfsp_checker.sv */
// Port-level checks for the drive filename syntax parser, bound to the top.
module dfsp_checker import dfsp_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [RES_W-1:0] m_tdata
);

  // Hold a stalled report.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("report changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("report shown right after reset");

  a_cmd_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4] == (m_tdata[12:5] != 8'd0)))
    else $error("has_command disagrees with cmd_len");

  a_param_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[31] |-> (m_tdata[39:32] == 8'd0))
    else $error("param_start set without a parameter");

endmodule

bind drive_filename_syntax_parser dfsp_checker u_dfsp_checker (.*);
